// ===== rtl/core/cif_pkg.sv =====
// shared types and constants for the choquet integral fusion core
`timescale 1ns / 1ps
`default_nettype none
package cif_pkg;

  // q value and weight widths
  localparam int unsigned Q_W      = 32;
  localparam int unsigned WGT_W    = 16;
  localparam int unsigned CNT_OUT_W = 7;

  // fuzzy measure arithmetic, sized for the largest agent count (64)
  localparam int unsigned SUM_W    = 22;   // running weight sum
  localparam int unsigned NUM_W    = 28;   // rank weighted numerator
  localparam int unsigned DEN_W    = 12;   // rank weight total, up to 2080
  localparam int unsigned MU_W     = 17;   // measure in q0.16, 1.0 included
  localparam int unsigned DIFF_W   = Q_W + 1;
  localparam int unsigned PROD_W   = DIFF_W + MU_W + 1;
  localparam int unsigned ACC_W    = 64;

  localparam logic [MU_W-1:0] MU_ONE = MU_W'(65536);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANK_RD,
    ST_RANK_CMP,
    ST_RANK_WR,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MUL,
    ST_ACC,
    ST_FINISH
  } cif_state_e;

endpackage
`default_nettype wire

// ===== rtl/core/cif_divider.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module cif_divider
  import cif_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] dividend_i,
  input  wire logic [DEN_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quotient_o
);

  localparam int unsigned IW = $clog2(NUM_W);

  logic              busy_q, done_q;
  logic [IW-1:0]     cnt_q;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DEN_W-1:0]  rem_q, rem_d, dvs_q;
  logic [DEN_W:0]    trial, diff;
  logic              ge;

  // one shift and subtract step
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    diff  = trial - {1'b0, dvs_q};
    rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    quo_d = {quo_q[NUM_W-2:0], ge};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + IW'(1);
        if (cnt_q == IW'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/choquet_integral_fusion_core.sv =====
// top level of the choquet integral fusion core
`timescale 1ns / 1ps
`default_nettype none
// Agents stream in one request per cycle as (q value, weight) pairs; the request with
// tlast closes the cell. The core then ranks the n held agents by weight with one
// comparator, pair by pair, and walks the sorted list from the top position down,
// forming each measure with a shared restoring divider (28 steps) and one 33x18
// multiplier; the bottom position skips the divider. s_axis_tready is low from the
// last request until the final hand-off to the output register. The result sits in
// an output register, so loading of the next cell starts while it waits.
module choquet_integral_fusion_core
  import cif_pkg::*;
#(
  parameter int unsigned MAX_AGENTS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // q_value[31:0], ref_weight[47:32]
  input  wire logic        s_axis_tlast,   // last_agent
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // fused_value[31:0], agent_count[38:32],
                                           // overflow[39]
);

  localparam int unsigned AW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_AGENTS + 1);

  cif_state_e state_q, state_d;

  logic [Q_W-1:0]   q_mem  [MAX_AGENTS];
  logic [WGT_W-1:0] w_mem  [MAX_AGENTS];
  logic [Q_W-1:0]   sq_mem [MAX_AGENTS];
  logic [WGT_W-1:0] sw_mem [MAX_AGENTS];

  logic [CW-1:0] cnt_q, n_q;
  logic          excess_q, exc_cell_q;
  logic [AW-1:0] a_q, b_q, rank_q, p_q;

  logic [WGT_W-1:0] wa_q, wb_q, sw_rd_q;
  logic [Q_W-1:0]   qa_q, sq_rd_q, sq_prev_q;

  logic [SUM_W-1:0]  s_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [MU_W-1:0]   mu_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic [Q_W-1:0]       out_val_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;
  logic                 out_ovf_q, out_vld_q;

  logic in_acc, load_ok, b_last, a_last, rank_hit, out_free;
  logic div_start, div_done;
  logic [NUM_W-1:0] div_quo, dividend;
  logic [CNT_OUT_W-1:0] m_cnt;
  logic [2*CNT_OUT_W-1:0] tri_prod;
  logic signed [ACC_W-1:0] rnd, res;
  logic sat;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign load_ok  = cnt_q < CW'(MAX_AGENTS);
  assign b_last   = (CW'(b_q) + CW'(1)) == n_q;
  assign a_last   = (CW'(a_q) + CW'(1)) == n_q;
  assign rank_hit = (wb_q < wa_q) || ((wb_q == wa_q) && (b_q < a_q));
  assign out_free = !out_vld_q || m_axis_tready;
  assign dividend = num_q + NUM_W'(den_q >> 1);

  // positions from the current one to the top, and their rank weight total
  assign m_cnt    = CNT_OUT_W'(n_q) - CNT_OUT_W'(p_q);
  assign tri_prod = m_cnt * (m_cnt + CNT_OUT_W'(1));

  // final rounding and saturation
  always_comb begin
    rnd = acc_q + ACC_W'(32768);
    res = rnd >>> 16;
    sat = !((&res[ACC_W-1:Q_W-1]) || !(|res[ACC_W-1:Q_W-1]));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_acc && s_axis_tlast) state_d = ST_RANK_RD;
      ST_RANK_RD:  state_d = ST_RANK_CMP;
      ST_RANK_CMP: state_d = b_last ? ST_RANK_WR : ST_RANK_RD;
      ST_RANK_WR:  state_d = a_last ? ST_SUM_RD : ST_RANK_RD;
      ST_SUM_RD:   state_d = ST_SUM_ACC;
      ST_SUM_ACC:  state_d = (p_q == '0) ? ST_MUL : ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_d = ST_MUL;
      ST_MUL:      state_d = ST_ACC;
      ST_ACC:      state_d = (p_q == '0) ? ST_FINISH : ST_SUM_RD;
      ST_FINISH:   if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_DIV_GO: div_start     = 1'b1;
      default:   ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      n_q        <= '0;
      excess_q   <= 1'b0;
      exc_cell_q <= 1'b0;
      a_q        <= '0;
      b_q        <= '0;
      rank_q     <= '0;
      p_q        <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // result valid: set on hand-off, cleared when taken
      if ((state_q == ST_FINISH) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tlast) begin
              n_q        <= load_ok ? cnt_q + CW'(1) : cnt_q;
              exc_cell_q <= excess_q || !load_ok;
              cnt_q      <= '0;
              excess_q   <= 1'b0;
              a_q        <= '0;
              b_q        <= '0;
              rank_q     <= '0;
            end else if (load_ok) begin
              cnt_q <= cnt_q + CW'(1);
            end else begin
              excess_q <= 1'b1;
            end
          end
        end
        ST_RANK_CMP: begin
          if (rank_hit) rank_q <= rank_q + AW'(1);
          b_q <= b_last ? '0 : b_q + AW'(1);
        end
        ST_RANK_WR: begin
          rank_q <= '0;
          a_q    <= a_q + AW'(1);
          if (a_last) p_q <= AW'(n_q - CW'(1));
        end
        ST_ACC: if (p_q != '0) p_q <= p_q - AW'(1);
        default: ;
      endcase
    end
  end

  // agent buffers, written on load, read for ranking
  always_ff @(posedge clk_i) begin
    if (in_acc && load_ok) begin
      q_mem[cnt_q[AW-1:0]] <= s_axis_tdata[31:0];
      w_mem[cnt_q[AW-1:0]] <= s_axis_tdata[47:32];
    end
    wa_q <= w_mem[a_q];
    qa_q <= q_mem[a_q];
    wb_q <= w_mem[b_q];
  end

  // sorted buffers, written by rank, read by position
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RANK_WR) begin
      sw_mem[rank_q] <= wa_q;
      sq_mem[rank_q] <= qa_q;
    end
    sw_rd_q   <= sw_mem[p_q];
    sq_rd_q   <= sq_mem[p_q];
    sq_prev_q <= sq_mem[p_q - AW'(1)];
  end

  // measure and accumulation datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_RANK_WR: begin
        s_q   <= '0;
        num_q <= '0;
        acc_q <= '0;
      end
      ST_SUM_RD: den_q <= DEN_W'(tri_prod >> 1);
      ST_SUM_ACC: begin
        s_q    <= s_q + SUM_W'(sw_rd_q);
        num_q  <= num_q + NUM_W'(s_q) + NUM_W'(sw_rd_q);
        diff_q <= $signed({sq_rd_q[Q_W-1], sq_rd_q}) -
                  ((p_q == '0) ? '0 : $signed({sq_prev_q[Q_W-1], sq_prev_q}));
        mu_q   <= MU_ONE;
      end
      ST_DIV_WAIT: if (div_done) mu_q <= div_quo[MU_W-1:0];
      ST_MUL: prod_q <= diff_q * $signed({1'b0, mu_q});
      ST_ACC: acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
      ST_FINISH: begin
        if (out_free) begin
          out_val_q <= sat ? (res[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                           : res[Q_W-1:0];
          out_cnt_q <= CNT_OUT_W'(n_q);
          out_ovf_q <= sat || exc_cell_q;
        end
      end
      default: ;
    endcase
  end

  cif_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_ovf_q, out_cnt_q, out_val_q};

`ifndef SYNTHESIS
  // a result always carries at least one agent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[38:32] != '0))
    else $error("result with no agents");

  // the divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_WAIT))
    else $error("divider done outside wait");

  // the fill count never passes the buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_AGENTS))
    else $error("fill count beyond depth");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for the choquet integral fusion core
`timescale 1ns / 1ps
module tb_top;
  import cif_pkg::*;

  localparam int unsigned NAG       = 16;
  localparam int unsigned CYC_LIMIT = 2000000;

  typedef struct {
    logic [31:0] q;
    logic [15:0] w;
    logic        last;
    logic        drain;   // hold this request until all results are back
  } agent_t;

  typedef struct {
    logic [31:0] fused;
    logic [6:0]  count;
    logic        ovf;
  } fused_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  agent_t agent_q[$];
  fused_t fused_q[$];
  agent_t cur;

  // held agents of the cell being loaded
  logic signed [31:0] cell_q [NAG];
  logic [15:0]        cell_w [NAG];
  int unsigned        held;
  logic               dropped;

  int unsigned cycles, agents_sent, cells_done, ovf_cells, errors;
  int unsigned stall_left;
  bit          stalled_once;

  choquet_integral_fusion_core #(.MAX_AGENTS(NAG)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // sort held agents by weight, build the measures and integrate
  function automatic fused_t fuse_cell();
    int          ord [NAG];
    int          cand, j;
    longint      acc, prev, res;
    longint unsigned num, den, mu;
    fused_t      r;
    acc = 0;
    prev = 0;
    for (int i = 0; i < held; i++) begin
      cand = i;
      j = i;
      while (j > 0 && cell_w[ord[j-1]] > cell_w[cand]) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = cand;
    end
    for (int p = 1; p <= held; p++) begin
      if (p == 1) begin
        mu = 65536;
      end else begin
        num = 0;
        den = 0;
        for (int k = p; k <= held; k++) begin
          num += longint'(k - p + 1) * cell_w[ord[k-1]];
          den += k - p + 1;
        end
        mu = (num + den / 2) / den;
      end
      acc += (longint'(cell_q[ord[p-1]]) - prev) * longint'(mu);
      prev = cell_q[ord[p-1]];
    end
    res = (acc + 32768) >>> 16;
    r.ovf = dropped;
    if (res > 64'sd2147483647) begin
      res = 64'sd2147483647;
      r.ovf = 1'b1;
    end
    if (res < -64'sd2147483648) begin
      res = -64'sd2147483648;
      r.ovf = 1'b1;
    end
    r.fused = res[31:0];
    r.count = held[6:0];
    return r;
  endfunction

  // take one accepted agent into the cell
  task automatic absorb_agent(agent_t a);
    if (held < NAG) begin
      cell_q[held] = a.q;
      cell_w[held] = a.w;
      held++;
    end else begin
      dropped = 1'b1;
    end
    if (a.last) begin
      fused_q = {fused_q, fuse_cell()};
      held = 0;
      dropped = 1'b0;
    end
  endtask

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_agent(cur);
        agents_sent++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (agent_q.size() > 0 && !(agent_q[0].drain && fused_q.size() > 0) &&
            !((cycles < 20000 || cycles > 40000) && $urandom_range(99) < 8)) begin
          cur = agent_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur.w, cur.q};
          s_axis_tlast  <= cur.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and result check
  always @(posedge clk_i) begin
    fused_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (fused_q.size() == 0) begin
          $error("result with no request pending: %h", m_axis_tdata);
          errors++;
        end else begin
          e = fused_q.pop_front();
          if (m_axis_tdata[31:0] !== e.fused) begin
            $error("fused_value exp %0d got %0d", $signed(e.fused),
                   $signed(m_axis_tdata[31:0]));
            errors++;
          end
          if (m_axis_tdata[38:32] !== e.count) begin
            $error("agent_count exp %0d got %0d", e.count, m_axis_tdata[38:32]);
            errors++;
          end
          if (m_axis_tdata[39] !== e.ovf) begin
            $error("overflow exp %0d got %0d", e.ovf, m_axis_tdata[39]);
            errors++;
          end
          if (e.ovf) ovf_cells++;
        end
        cells_done++;
      end
      // one long hold-off so the core backs up into its input
      if (cells_done == 12 && !stalled_once) begin
        stalled_once = 1'b1;
        stall_left = 4000;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !((cycles < 20000 || cycles > 40000) && $urandom_range(99) < 8);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_agent(logic [31:0] q, logic [15:0] w, logic last, logic drain = 1'b0);
    agent_t a;
    a.q = q;
    a.w = w;
    a.last = last;
    a.drain = drain;
    agent_q = {agent_q, a};
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(131072)) - 65536);
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [15:0] rand_w();
    case ($urandom_range(2))
      0: return 16'($urandom);
      1: return 16'($urandom_range(3) * 16'h5555);   // coarse values, many ties
      default: return $urandom_range(1) ? 16'hffff : 16'h0000;
    endcase
  endfunction

  initial begin
    int unsigned total, len, pick;
    bit          drain_set, dr;
    held = 0;
    dropped = 1'b0;
    drain_set = 1'b0;
    // single agents at the field extremes
    add_agent(32'h7fffffff, 16'h0000, 1'b1);
    add_agent(32'h80000000, 16'hffff, 1'b1);
    // two agents, extremes swapped, then tied weights
    add_agent(32'h80000000, 16'h0000, 1'b0);
    add_agent(32'h7fffffff, 16'hffff, 1'b1);
    add_agent(32'h00010000, 16'h8000, 1'b0);
    add_agent(32'hffff0000, 16'h8000, 1'b1);
    // a cell beyond capacity, last two agents dropped
    for (int i = 0; i < 18; i++)
      add_agent(32'(i * 32'h00012345) ^ 32'ha5a50000, 16'(16'hffff - i * 16'h0f0f), i == 17);
    total = agent_q.size();
    while (total < 1250) begin
      pick = $urandom_range(99);
      len = pick < 85 ? $urandom_range(1, 6) : pick < 95 ? $urandom_range(7, 16)
                                                         : $urandom_range(17, 19);
      // first cell past the midpoint waits until every result is back
      dr = !drain_set && total >= 600;
      if (dr) drain_set = 1'b1;
      for (int i = 0; i < len; i++)
        add_agent(rand_q(), rand_w(), i == len - 1, dr && i == 0);
      total += len;
    end
    total = agent_q.size();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (agents_sent < total || fused_q.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("run covered %0d agents in %0d cells, %0d cells flagged overflow",
             agents_sent, cells_done, ovf_cells);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cif_pkg.sv
rtl/core/cif_divider.sv
rtl/core/choquet_integral_fusion_core.sv
verif/tb_top.sv
